// File: rtl/sensor_ring_bearing_and_range_top_macros.svh
// Assertion macros used by the sensor ring bearing and range top level.
// Each macro expects a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef SENSOR_RING_BEARING_AND_RANGE_TOP_MACROS_SVH
`define SENSOR_RING_BEARING_AND_RANGE_TOP_MACROS_SVH

// Same-cycle implication.
`define SRBR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define SRBR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/srbr_pkg.sv
// Package for the sensor ring bearing and range block: constants, tables, types.
// No dependencies; the interface, CORDIC and top files use it by scoped names.
`default_nettype none

package srbr_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LEVEL = 2'd0;
    localparam logic [1:0] CFG_SIDE  = 2'd1;
    localparam int unsigned CFG_IDX_W = 2;

    localparam int unsigned LEVEL_RESET = 920;
    localparam int unsigned SIDE_RESET  = 600;

    // Sensor unit directions in Q1.15, sensor 0 at 22.5 degrees.
    localparam logic signed [15:0] DIR_X [8] = '{
        16'sd12517, 16'sd30245, 16'sd30245, 16'sd12517,
        -16'sd12517, -16'sd30245, -16'sd30245, -16'sd12517
    };
    localparam logic signed [15:0] DIR_Y [8] = '{
        16'sd30245, 16'sd12517, -16'sd12517, -16'sd30245,
        -16'sd30245, -16'sd12517, 16'sd12517, 16'sd30245
    };

    // Angle accumulator: degrees times 65536.
    localparam int unsigned Z_W   = 24;
    localparam int unsigned ZC_W  = 23;
    localparam int unsigned DEG90  = 90 * 65536;
    localparam int unsigned DEG45  = 45 * 65536;
    localparam int unsigned DEG180 = 180 * 65536;

    // Inverse CORDIC gain in Q0.30, and the fractional bits dropped after it.
    localparam logic [29:0] INV_GAIN = 30'd652032874;
    localparam int unsigned GAIN_SHIFT = 45;
    localparam int unsigned LO_BITS = 17;

    // Range scaling by 7/15 through a reciprocal, and its saturation.
    localparam int unsigned RANGE_CLAMP = 2195;
    localparam logic [16:0] RECIP15 = 17'd69906;
    localparam logic [13:0] RECIP5  = 14'd13108;
    localparam logic [9:0]  CODE_MAX = 10'd1023;

    typedef struct packed {
        logic no_target;
        logic sx_neg;
        logic sy_neg;
        logic a_zero;
        logic b_zero;
        logic a_eq_b;
        logic forced;
    } t_tag;

    // atan(2^-i) in degrees times 65536, rounded.
    function automatic logic [21:0] atan_deg(input int unsigned i);
        logic [21:0] v;
        case (i)
            0:       v = 22'd2949120;
            1:       v = 22'd1740967;
            2:       v = 22'd919879;
            3:       v = 22'd466945;
            4:       v = 22'd234379;
            5:       v = 22'd117304;
            6:       v = 22'd58666;
            7:       v = 22'd29335;
            8:       v = 22'd14668;
            9:       v = 22'd7334;
            10:      v = 22'd3667;
            11:      v = 22'd1833;
            12:      v = 22'd917;
            13:      v = 22'd458;
            14:      v = 22'd229;
            15:      v = 22'd115;
            16:      v = 22'd57;
            17:      v = 22'd29;
            18:      v = 22'd14;
            19:      v = 22'd7;
            20:      v = 22'd4;
            21:      v = 22'd2;
            22:      v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/srbr_if.sv
// Handshake channel interfaces for the sensor ring block: samples, results, config.
// Depends on srbr_pkg for the register index width.
`default_nettype none

interface srbr_sample_if #(parameter int SAMPLE_BITS = 10);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_0;
    logic [SAMPLE_BITS-1:0] sample_1;
    logic [SAMPLE_BITS-1:0] sample_2;
    logic [SAMPLE_BITS-1:0] sample_3;
    logic [SAMPLE_BITS-1:0] sample_4;
    logic [SAMPLE_BITS-1:0] sample_5;
    logic [SAMPLE_BITS-1:0] sample_6;
    logic [SAMPLE_BITS-1:0] sample_7;
    modport source (output valid, sample_0, sample_1, sample_2, sample_3,
                    sample_4, sample_5, sample_6, sample_7, input ready);
    modport sink   (input valid, sample_0, sample_1, sample_2, sample_3,
                    sample_4, sample_5, sample_6, sample_7, output ready);
endinterface

interface srbr_result_if;
    logic       valid;
    logic       ready;
    logic [9:0] bearing_code;
    logic [9:0] range_code;
    logic       no_target;
    modport source (output valid, bearing_code, range_code, no_target, input ready);
    modport sink   (input valid, bearing_code, range_code, no_target, output ready);
endinterface

interface srbr_cfg_if #(parameter int SAMPLE_BITS = 10);
    logic                           valid;
    logic                           ready;
    logic [srbr_pkg::CFG_IDX_W-1:0] index;
    logic [SAMPLE_BITS-1:0]         data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/srbr_cordic.sv
// Pipelined vectoring CORDIC, one rotation per register stage, with a tag carried along.
// Depends on srbr_pkg for the angle table, angle width and tag type.
`default_nettype none

module srbr_cordic #(
    parameter int W     = 31,
    parameter int STEPS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_vld,
    input  wire logic signed [W-1:0]           i_x,
    input  wire logic signed [W-1:0]           i_y,
    input  wire srbr_pkg::t_tag                i_tag,
    output logic                               o_vld,
    output logic signed [W-1:0]                o_x,
    output logic signed [srbr_pkg::Z_W-1:0]    o_z,
    output srbr_pkg::t_tag                     o_tag
);

    logic                            r_vld [STEPS];
    logic signed [W-1:0]             r_x   [STEPS];
    logic signed [W-1:0]             r_y   [STEPS];
    logic signed [srbr_pkg::Z_W-1:0] r_z   [STEPS];
    srbr_pkg::t_tag                  r_tag [STEPS];

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        localparam logic signed [srbr_pkg::Z_W-1:0] T =
            srbr_pkg::Z_W'(srbr_pkg::atan_deg(g));
        logic                            vin;
        logic signed [W-1:0]             xin, yin, xs, ys;
        logic signed [srbr_pkg::Z_W-1:0] zin;
        srbr_pkg::t_tag                  tin;
        logic signed [W-1:0]             n_x, n_y;
        logic signed [srbr_pkg::Z_W-1:0] n_z;

        if (g == 0) begin : g_head
            assign vin = i_vld;
            assign xin = i_x;
            assign yin = i_y;
            assign zin = '0;
            assign tin = i_tag;
        end else begin : g_body
            assign vin = r_vld[g-1];
            assign xin = r_x[g-1];
            assign yin = r_y[g-1];
            assign zin = r_z[g-1];
            assign tin = r_tag[g-1];
        end

        assign xs = xin >>> g;
        assign ys = yin >>> g;

        always_comb begin
            if (yin > 0) begin
                n_x = xin + ys;
                n_y = yin - xs;
                n_z = zin + T;
            end else begin
                n_x = xin - ys;
                n_y = yin + xs;
                n_z = zin - T;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vin;
            end
            if (i_en) begin
                r_x[g]   <= n_x;
                r_y[g]   <= n_y;
                r_z[g]   <= n_z;
                r_tag[g] <= tin;
            end
        end
    end

    assign o_vld = r_vld[STEPS-1];
    assign o_x   = r_x[STEPS-1];
    assign o_z   = r_z[STEPS-1];
    assign o_tag = r_tag[STEPS-1];

endmodule

`default_nettype wire

// File: rtl/sensor_ring_bearing_and_range_top.sv
// Top level of the sensor ring bearing and range estimator.
// Depends on srbr_pkg, srbr_if, srbr_cordic and the assertion macro header.
`default_nettype none

// The block takes one request of eight ring samples per clock, unless the output
// stalls, and returns one result per request, in order: a bearing code 2..936 over
// a full turn, a range code 0..1023, and a no-target flag (bearing 1023, range 0)
// when the weighted direction sum is exactly zero. The pipeline is fully
// registered: three stages form the weighted vector (products, sum, magnitude
// split), CORDIC_STEPS stages run one CORDIC rotation each, and two more stages
// turn angle and length into codes, followed by the output register. Throughput
// is one request per cycle while results are taken. All stages advance together:
// when the output register holds a result that is not taken, the whole pipeline,
// and the input ready, hold as well, so nothing is dropped or repeated.
// Configuration writes are always taken and must be made only while no request
// is in flight.
module sensor_ring_bearing_and_range_top #(
    parameter int SAMPLE_BITS  = 10,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    srbr_sample_if.sink   i_smp,
    srbr_result_if.source o_res,
    srbr_cfg_if.sink      i_cfg
);

`include "sensor_ring_bearing_and_range_top_macros.svh"

    localparam int SB    = SAMPLE_BITS;
    localparam int PW    = SB + 17;          // one weighted direction component
    localparam int SUM_W = SB + 20;          // sum of eight components
    localparam int CW    = SB + 21;          // CORDIC datapath, room for gain growth
    localparam int XU_W  = CW - 1;           // non-negative final length
    localparam int HI_W  = XU_W - srbr_pkg::LO_BITS;
    localparam int FW    = XU_W + 30;        // full length times inverse gain
    localparam int R_W   = FW - srbr_pkg::GAIN_SHIFT;

    // Configuration registers.
    logic [SB-1:0] r_level, r_side;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= SB'(srbr_pkg::LEVEL_RESET);
            r_side  <= SB'(srbr_pkg::SIDE_RESET);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                srbr_pkg::CFG_LEVEL: r_level <= i_cfg.data;
                srbr_pkg::CFG_SIDE:  r_side  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Global advance: every stage moves when the output register is free or taken.
    logic w_adv;
    logic r_ovld;

    assign w_adv       = !r_ovld || o_res.ready;
    assign i_smp.ready = w_adv;

    // Stage 1: weights and the sixteen constant products.
    logic [SB-1:0]         w_s [8];
    logic signed [PW-1:0]  n_px [8], n_py [8];
    logic                  n_dark, n_forced;
    logic                  r_v1, r1_forced;
    logic signed [PW-1:0]  r1_px [8], r1_py [8];

    assign w_s[0] = i_smp.sample_0;
    assign w_s[1] = i_smp.sample_1;
    assign w_s[2] = i_smp.sample_2;
    assign w_s[3] = i_smp.sample_3;
    assign w_s[4] = i_smp.sample_4;
    assign w_s[5] = i_smp.sample_5;
    assign w_s[6] = i_smp.sample_6;
    assign w_s[7] = i_smp.sample_7;

    always_comb begin
        logic signed [SB:0] w;
        n_dark = 1'b1;
        for (int k = 0; k < 8; k++) begin
            if (w_s[k] <= r_level) begin
                n_dark = 1'b0;
            end
        end
        for (int k = 0; k < 8; k++) begin
            w = $signed({1'b0, r_level}) - $signed({1'b0, w_s[k]});
            if (n_dark) begin
                w = '0;
            end
            n_px[k] = PW'(w) * PW'(srbr_pkg::DIR_X[k]);
            n_py[k] = PW'(w) * PW'(srbr_pkg::DIR_Y[k]);
        end
        n_forced = (w_s[0] <= r_level) && (w_s[7] <= r_level) &&
                   (w_s[1] >= r_side) && (w_s[6] >= r_side);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_smp.valid;
        end
        if (w_adv) begin
            r1_px     <= n_px;
            r1_py     <= n_py;
            r1_forced <= n_forced;
        end
    end

    // Stage 2: exact vector sums.
    logic signed [SUM_W-1:0] n_sx, n_sy, r2_sx, r2_sy;
    logic                    r_v2, r2_forced;

    always_comb begin
        n_sx = '0;
        n_sy = '0;
        for (int k = 0; k < 8; k++) begin
            n_sx = n_sx + SUM_W'(r1_px[k]);
            n_sy = n_sy + SUM_W'(r1_py[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv) begin
            r_v2 <= r_v1;
        end
        if (w_adv) begin
            r2_sx     <= n_sx;
            r2_sy     <= n_sy;
            r2_forced <= r1_forced;
        end
    end

    // Stage 3: magnitudes and the flags that the angle fix-up needs later.
    logic signed [CW-1:0] n_a, n_b, r3_a, r3_b;
    srbr_pkg::t_tag       n_tag, r3_tag;
    logic                 r_v3;

    always_comb begin
        n_a = r2_sx[SUM_W-1] ? -CW'(r2_sx) : CW'(r2_sx);
        n_b = r2_sy[SUM_W-1] ? -CW'(r2_sy) : CW'(r2_sy);
        n_tag.no_target = (r2_sx == '0) && (r2_sy == '0);
        n_tag.sx_neg    = r2_sx[SUM_W-1];
        n_tag.sy_neg    = r2_sy[SUM_W-1];
        n_tag.a_zero    = (r2_sx == '0);
        n_tag.b_zero    = (r2_sy == '0);
        n_tag.a_eq_b    = (n_a == n_b);
        n_tag.forced    = r2_forced;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v3 <= r_v2;
        end
        if (w_adv) begin
            r3_a   <= n_a;
            r3_b   <= n_b;
            r3_tag <= n_tag;
        end
    end

    // CORDIC rotations.
    logic                            c_vld;
    logic signed [CW-1:0]            c_x;
    logic signed [srbr_pkg::Z_W-1:0] c_z;
    srbr_pkg::t_tag                  c_tag;

    srbr_cordic #(
        .W     (CW),
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r_v3),
        .i_x     (r3_a),
        .i_y     (r3_b),
        .i_tag   (r3_tag),
        .o_vld   (c_vld),
        .o_x     (c_x),
        .o_z     (c_z),
        .o_tag   (c_tag)
    );

    // Post stage 1: angle clamp and overrides, split gain multiply.
    logic [srbr_pkg::ZC_W-1:0]          n_zc, r4_zc;
    logic [XU_W-1:0]                    w_xu;
    logic [srbr_pkg::LO_BITS+29:0]      n_pl, r4_pl;
    logic [HI_W+29:0]                   n_ph, r4_ph;
    srbr_pkg::t_tag                     r4_tag;
    logic                               r_v4;

    always_comb begin
        if (c_z < 0) begin
            n_zc = '0;
        end else if (c_z > srbr_pkg::Z_W'(srbr_pkg::DEG90)) begin
            n_zc = srbr_pkg::ZC_W'(srbr_pkg::DEG90);
        end else begin
            n_zc = c_z[srbr_pkg::ZC_W-1:0];
        end
        if (c_tag.b_zero) begin
            n_zc = '0;
        end else if (c_tag.a_zero) begin
            n_zc = srbr_pkg::ZC_W'(srbr_pkg::DEG90);
        end else if (c_tag.a_eq_b) begin
            n_zc = srbr_pkg::ZC_W'(srbr_pkg::DEG45);
        end
        w_xu = c_x[CW-1] ? '0 : c_x[XU_W-1:0];
        n_pl = (srbr_pkg::LO_BITS+30)'(w_xu[srbr_pkg::LO_BITS-1:0]) *
               (srbr_pkg::LO_BITS+30)'(srbr_pkg::INV_GAIN);
        n_ph = (HI_W+30)'(w_xu[XU_W-1:srbr_pkg::LO_BITS]) *
               (HI_W+30)'(srbr_pkg::INV_GAIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_adv) begin
            r_v4 <= c_vld;
        end
        if (w_adv) begin
            r4_zc  <= n_zc;
            r4_pl  <= n_pl;
            r4_ph  <= n_ph;
            r4_tag <= c_tag;
        end
    end

    // Post stage 2: whole degrees to the 1..360 compass turn, length recombined.
    logic [23:0]        w_m;
    logic signed [10:0] w_d, w_t1, w_t2;
    logic [8:0]         n_t, r5_t;
    logic [FW-1:0]      w_full;
    logic [R_W-1:0]     w_r;
    logic [11:0]        n_rc, r5_rc;
    srbr_pkg::t_tag     r5_tag;
    logic               r_v5;

    always_comb begin
        w_m = r4_tag.sx_neg ? 24'(srbr_pkg::DEG180) - 24'(r4_zc) : 24'(r4_zc);
        w_d = r4_tag.sy_neg ? -$signed({3'b000, w_m[23:16]}) : $signed({3'b000, w_m[23:16]});
        w_t1 = (w_d > 0) ? w_d : w_d + 11'sd360;
        w_t2 = 11'sd450 - w_t1;
        if (w_t2 > 11'sd360) begin
            w_t2 = w_t2 - 11'sd360;
        end
        n_t = w_t2[8:0];
        w_full = (FW'(r4_ph) << srbr_pkg::LO_BITS) + FW'(r4_pl);
        w_r    = w_full[FW-1:srbr_pkg::GAIN_SHIFT];
        n_rc   = (w_r > R_W'(srbr_pkg::RANGE_CLAMP)) ? 12'(srbr_pkg::RANGE_CLAMP)
                                                     : 12'(w_r);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_adv) begin
            r_v5 <= r_v4;
        end
        if (w_adv) begin
            r5_t   <= n_t;
            r5_rc  <= n_rc;
            r5_tag <= r4_tag;
        end
    end

    // Post stage 3: codes by reciprocal multiplies, then the output register.
    logic [12:0] w_t13;
    logic [26:0] w_bprod;
    logic [14:0] w_r7;
    logic [31:0] w_rprod;
    logic [11:0] w_rq;
    logic [9:0]  n_bear, n_range;
    logic [9:0]  r_bear, r_range;
    logic        r_nt;

    always_comb begin
        w_t13   = 13'(r5_t) * 13'd13;
        w_bprod = 27'(w_t13) * 27'(srbr_pkg::RECIP5);
        w_r7    = 15'(r5_rc) * 15'd7;
        w_rprod = 32'(w_r7) * 32'(srbr_pkg::RECIP15);
        w_rq    = w_rprod[31:20];
        n_bear  = w_bprod[25:16];
        n_range = (w_rq > 12'(srbr_pkg::CODE_MAX)) ? srbr_pkg::CODE_MAX : w_rq[9:0];
        if (r5_tag.forced) begin
            n_range = '0;
        end
        if (r5_tag.no_target) begin
            n_bear  = srbr_pkg::CODE_MAX;
            n_range = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_adv) begin
            r_ovld <= r_v5;
        end
        if (w_adv) begin
            r_bear  <= n_bear;
            r_range <= n_range;
            r_nt    <= r5_tag.no_target;
        end
    end

    assign o_res.valid        = r_ovld;
    assign o_res.bearing_code = r_bear;
    assign o_res.range_code   = r_range;
    assign o_res.no_target    = r_nt;

    // A zero vector must report the no-target codes.
    `SRBR_ASSERT_NOW(a_no_target_codes, r_ovld && r_nt, (r_bear == srbr_pkg::CODE_MAX) && (r_range == '0))
    // A real target always has a bearing inside the full turn.
    `SRBR_ASSERT_NOW(a_bearing_in_turn, r_ovld && !r_nt, r_bear <= 10'd936)
    // While stalled, the stage 1, stage 2 and post stage 2 valid flags hold.
    `SRBR_ASSERT_NEXT(a_stall_holds, !w_adv, $stable(r_v1) && $stable(r_v2) && $stable(r_v5))

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the sensor ring bearing and range estimator.
// Depends on srbr_pkg, the srbr interfaces and sensor_ring_bearing_and_range_top.
// Predicts bearing, range and no-target codes per request and compares in order.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB         = 10;
    localparam int STEPS      = 16;
    localparam int LATENCY    = STEPS + 6;
    localparam int WATCH_MAX  = 20000;
    localparam int N_RANDOM   = 1330;

    typedef struct packed {
        logic [SB-1:0] s7, s6, s5, s4, s3, s2, s1, s0;
    } t_ring;

    typedef struct packed {
        logic [9:0] bearing;
        logic [9:0] range;
        logic       no_target;
    } t_fix;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    srbr_sample_if #(.SAMPLE_BITS(SB)) smp ();
    srbr_result_if                     res ();
    srbr_cfg_if    #(.SAMPLE_BITS(SB)) cfg ();

    sensor_ring_bearing_and_range_top #(.SAMPLE_BITS(SB), .CORDIC_STEPS(STEPS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp.sink),
        .o_res   (res.source),
        .i_cfg   (cfg.sink)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The predictor keeps its own copy of both thresholds.
    logic [SB-1:0] level_q = SB'(srbr_pkg::LEVEL_RESET);
    logic [SB-1:0] side_q  = SB'(srbr_pkg::SIDE_RESET);

    t_ring ring_q[$];   // requests waiting for the driver
    t_fix  fix_q[$];    // predicted fixes waiting for the monitor
    int    send_idle_pct = 15;
    int    recv_idle_pct = 57;
    int    recv_hold = 0;
    int    errors = 0;
    int    quiet = 0;
    bit    in_took = 1'b0;

    function automatic longint fshift(longint v, int s);
        if (v >= 0) return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    // Bit-exact prediction of one fix from one ring snapshot.
    function automatic t_fix predict_fix(t_ring r);
        longint atan_tab[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                 58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                 229, 115};
        longint dx[8] = '{12517, 30245, 30245, 12517, -12517, -30245, -30245, -12517};
        longint dy[8] = '{30245, 12517, -12517, -30245, -30245, -12517, 12517, 30245};
        logic [SB-1:0] s[8];
        bit     dark;
        longint sx, sy, a, b, x, y, z, xs, ys, m, deg, t, rg, w;
        t_fix   f;
        s = '{r.s0, r.s1, r.s2, r.s3, r.s4, r.s5, r.s6, r.s7};
        dark = 1;
        sx = 0;
        sy = 0;
        foreach (s[i]) if (s[i] <= level_q) dark = 0;
        if (!dark) begin
            foreach (s[i]) begin
                w = longint'(level_q) - longint'(s[i]);
                sx += dx[i] * w;
                sy += dy[i] * w;
            end
        end
        if (sx == 0 && sy == 0) begin
            f.bearing = 10'd1023;
            f.range = 10'd0;
            f.no_target = 1'b1;
            return f;
        end
        a = sx < 0 ? -sx : sx;
        b = sy < 0 ? -sy : sy;
        x = a;
        y = b;
        z = 0;
        for (int i = 0; i < STEPS; i++) begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (y > 0) begin
                x += ys; y -= xs; z += atan_tab[i];
            end else begin
                x -= ys; y += xs; z -= atan_tab[i];
            end
        end
        if (z < 0) z = 0;
        if (z > 90 * 65536) z = 90 * 65536;
        if (b == 0) z = 0;
        else if (a == 0) z = 90 * 65536;
        else if (a == b) z = 45 * 65536;
        m = sx >= 0 ? z : 180 * 65536 - z;
        deg = m >>> 16;
        if (sy < 0) deg = -deg;
        t = deg > 0 ? deg : deg + 360;
        t = 450 - t;
        if (t > 360) t -= 360;
        f.bearing = 10'((t * 936) / 360);
        if (x < 0) x = 0;
        rg = (x * 652032874) >>> 45;
        rg = (rg * 7) / 15;
        if (rg > 1023) rg = 1023;
        if (s[0] <= level_q && s[7] <= level_q && s[1] >= side_q && s[6] >= side_q)
            rg = 0;
        f.range = 10'(rg);
        f.no_target = 1'b0;
        return f;
    endfunction

    // The input handshake is sampled at the rising edge; the prediction is made
    // there and the flag tells the driver at the next falling edge.
    always @(posedge i_clk) begin
        in_took = 1'b0;
        if (i_rst_n && smp.valid && smp.ready) begin
            fix_q.push_back(predict_fix(ring_q.pop_front()));
            in_took = 1'b1;
        end
    end

    // Driver: offers queued requests and holds one that has not been taken.
    always @(negedge i_clk) begin
        if (ring_q.size() > 0 && !(smp.valid && !in_took)
                && $urandom_range(99) < send_idle_pct) begin
            smp.valid <= 1'b0;
        end else if (ring_q.size() > 0) begin
            smp.valid <= 1'b1;
            {smp.sample_7, smp.sample_6, smp.sample_5, smp.sample_4,
             smp.sample_3, smp.sample_2, smp.sample_1, smp.sample_0} <= ring_q[0];
        end else begin
            smp.valid <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && smp.valid && smp.ready) quiet <= 0;
        else if (i_rst_n && res.valid && res.ready) quiet <= 0;
        else quiet <= quiet + 1;
    end

    // Monitor: checks each taken fix against the oldest prediction.
    always @(posedge i_clk) begin
        t_fix exp_f;
        if (i_rst_n && res.valid && res.ready) begin
            if (fix_q.size() == 0) begin
                $error("fix with no request outstanding");
                errors++;
            end else begin
                exp_f = fix_q.pop_front();
                if (res.bearing_code !== exp_f.bearing) begin
                    $error("bearing_code expected %0d actual %0d",
                           exp_f.bearing, res.bearing_code);
                    errors++;
                end
                if (res.range_code !== exp_f.range) begin
                    $error("range_code expected %0d actual %0d",
                           exp_f.range, res.range_code);
                    errors++;
                end
                if (res.no_target !== exp_f.no_target) begin
                    $error("no_target expected %0d actual %0d",
                           exp_f.no_target, res.no_target);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stalls, or a long counted hold-off when requested.
    always @(negedge i_clk) begin
        if (recv_hold > 0) begin
            res.ready <= 1'b0;
            recv_hold <= recv_hold - 1;
        end else begin
            res.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (quiet >= WATCH_MAX) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(logic [srbr_pkg::CFG_IDX_W-1:0] idx, logic [SB-1:0] val);
        @(negedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge i_clk); while (!cfg.ready);
        if (idx == srbr_pkg::CFG_LEVEL) level_q = val;
        else if (idx == srbr_pkg::CFG_SIDE) side_q = val;
        @(negedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    // Waits until every request has come back, then lets the pipeline drain.
    task automatic drain();
        while (ring_q.size() > 0 || fix_q.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic t_ring rand_ring(logic [SB-1:0] lvl);
        t_ring r;
        int mode;
        r = '0;
        mode = $urandom_range(9);
        for (int i = 0; i < 8; i++) begin
            logic [SB-1:0] v;
            case (mode)
                0:       v = SB'($urandom);
                1:       v = (lvl < 1023) ? SB'($urandom_range(1023, lvl + 1)) : SB'($urandom);
                2:       v = lvl;
                default: v = SB'($urandom_range(lvl + 60 > 1023 ? 1023 : lvl + 60,
                                                lvl > 200 ? lvl - 200 : 0));
            endcase
            r[i*SB +: SB] = v;
        end
        if (mode == 4) r.s1 = r.s6;   // symmetric side pair for the forced-range test
        return r;
    endfunction

    initial begin
        logic [SB-1:0] levels[6] = '{10'd920, 10'd0, 10'd1023, 10'd512, 10'd300, 10'd1000};
        logic [SB-1:0] sides[6]  = '{10'd600, 10'd1023, 10'd0, 10'd400, 10'd800, 10'd1};
        smp.valid = 1'b0;
        {smp.sample_7, smp.sample_6, smp.sample_5, smp.sample_4,
         smp.sample_3, smp.sample_2, smp.sample_1, smp.sample_0} = '0;
        res.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at reset thresholds: extremes, all dark, zero vector,
        // single sensors, opposite pairs, the forced range case and the axes.
        ring_q.push_back('0);
        ring_q.push_back('1);
        ring_q.push_back({8{10'd920}});
        ring_q.push_back({8{10'd921}});
        for (int i = 0; i < 8; i++) begin
            t_ring r;
            r = {8{10'd1023}};
            r[i*SB +: SB] = 10'd0;
            ring_q.push_back(r);
        end
        ring_q.push_back({10'd0, 10'd700, 10'd920, 10'd920, 10'd920, 10'd920,
                          10'd700, 10'd0});
        ring_q.push_back({10'd0, 10'd599, 10'd920, 10'd920, 10'd920, 10'd920,
                          10'd600, 10'd0});
        ring_q.push_back({10'd0, 10'd0, 10'd920, 10'd920, 10'd0, 10'd0,
                          10'd920, 10'd920});
        ring_q.push_back({10'd920, 10'd920, 10'd0, 10'd0, 10'd920, 10'd920,
                          10'd0, 10'd0});
        ring_q.push_back({10'd0, 10'd920, 10'd920, 10'd920, 10'd0, 10'd920,
                          10'd920, 10'd920});
        ring_q.push_back({10'd100, 10'd200, 10'd300, 10'd400, 10'd500, 10'd600,
                          10'd700, 10'd800});
        drain();

        // Random phases over threshold settings and idle patterns.
        for (int p = 0; p < 6; p++) begin
            write_reg(srbr_pkg::CFG_LEVEL, levels[p]);
            write_reg(srbr_pkg::CFG_SIDE, sides[p]);
            case (p % 3)
                0: begin send_idle_pct = 15; recv_idle_pct = 57; end
                1: begin send_idle_pct = 57; recv_idle_pct = 15; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (p == 2) recv_hold = 3 * LATENCY;
            for (int k = 0; k < N_RANDOM / 6; k++) begin
                ring_q.push_back(rand_ring(levels[p]));
                if (k % 50 == 49) begin
                    while (ring_q.size() > 0 || fix_q.size() > 0) @(posedge i_clk);
                end
                while (ring_q.size() > 8) @(posedge i_clk);
            end
            drain();
        end

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Any prediction left over would be caught by drain never returning;
    // the watchdog then ends the run.
endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/srbr_pkg.sv
rtl/srbr_if.sv
rtl/srbr_cordic.sv
rtl/sensor_ring_bearing_and_range_top.sv
tb/sv/tb_top.sv
